// ===== hw/rtl/csel_pkg.sv =====
`default_nettype none

package csel_pkg;

	localparam int unsigned NUM_CELLS_DEF = 8736;
	localparam int unsigned CELL_W = 14;
	localparam int unsigned SHOWER_W = 10;
	localparam int unsigned CFG_W = 14;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [11:0] THETA_LOW = 12'd272;
	localparam logic [11:0] THETA_HIGH = 12'd2400;
	localparam logic [13:0] LOW_ENERGY_MEV = 14'd500;

	localparam logic [13:0] ENERGY_CUT_RST = 14'd20;
	localparam logic [10:0] SHAPE_RATIO_CUT_RST = 11'd768;
	localparam logic [11:0] WIDTH_CUT_RST = 12'd96;
	localparam logic [7:0] HIT_COUNT_CUT_RST = 8'd0;
	localparam logic [3:0] DET_ID_RST = 4'd5;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_HIT = 2'd1,
		REQ_HEADER = 2'd2,
		REQ_CELL = 2'd3
	} req_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENERGY_CUT = 3'd0,
		CFG_SHAPE_RATIO_CUT = 3'd1,
		CFG_WIDTH_CUT = 3'd2,
		CFG_HIT_COUNT_CUT = 3'd3,
		CFG_DET_ID = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_READ
	} back_state_t;

	typedef struct packed {
		logic [13:0] energy_cut;
		logic [10:0] shape_ratio_cut;
		logic [11:0] width_cut;
		logic [7:0] hit_count_cut;
		logic [3:0] det_id;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		req_e_t req;
		logic [CELL_W-1:0] cell_addr;
		logic cell_use;
		logic [SHOWER_W-1:0] shower_id;
		logic cuts_ok;
		logic last;
	} q_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/calorimeter_photon_selector.sv =====
// flow: an accepted item enters the queue; the back end pops it when idle and the result
// register is free; a header result is registered from the popped item, a shower cell
// result only after the registered mark memory read, and no new item is taken meanwhile;
// a clear request sweeps the mark memory, one entry cleared per cycle, before the next item
// reset: config registers go to defaults, shower state clears, then a clearing pass over all
// NUM_CELLS mark memory entries runs; items queue up meanwhile, up to 2
`default_nettype none

module calorimeter_photon_selector
	import csel_pkg::*;
#(
	parameter int unsigned NUM_CELLS = NUM_CELLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] req_type,
	input wire logic [3:0] detector_id,
	input wire logic [13:0] cell_id,
	input wire logic [9:0] shower_id,
	input wire logic [13:0] shower_energy,
	input wire logic [11:0] polar_angle,
	input wire logic [10:0] shape_ratio,
	input wire logic [11:0] shower_width,
	input wire logic [7:0] hit_count,
	input wire logic [7:0] quality,
	input wire logic last_of_shower,
	output logic out_valid,
	input wire logic out_ready,
	output logic [9:0] result_shower_id,
	output logic is_photon
);

	cfg_t cfg_q;
	q_item_t front_item;
	q_item_t back_item;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic q_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_cut <= ENERGY_CUT_RST;
			cfg_q.shape_ratio_cut <= SHAPE_RATIO_CUT_RST;
			cfg_q.width_cut <= WIDTH_CUT_RST;
			cfg_q.hit_count_cut <= HIT_COUNT_CUT_RST;
			cfg_q.det_id <= DET_ID_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENERGY_CUT: cfg_q.energy_cut <= cfg_data[13:0];
				CFG_SHAPE_RATIO_CUT: cfg_q.shape_ratio_cut <= cfg_data[10:0];
				CFG_WIDTH_CUT: cfg_q.width_cut <= cfg_data[11:0];
				CFG_HIT_COUNT_CUT: cfg_q.hit_count_cut <= cfg_data[7:0];
				CFG_DET_ID: cfg_q.det_id <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;

	csel_front #(
		.NUM_CELLS(NUM_CELLS)
	) u_front (
		.cfg(cfg_q),
		.req_type(req_type),
		.detector_id(detector_id),
		.cell_id(cell_id),
		.shower_id(shower_id),
		.shower_energy(shower_energy),
		.polar_angle(polar_angle),
		.shape_ratio(shape_ratio),
		.shower_width(shower_width),
		.hit_count(hit_count),
		.quality(quality),
		.last_of_shower(last_of_shower),
		.item(front_item)
	);

	csel_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(front_item),
		.full(q_full),
		.pop_valid(q_valid),
		.pop(q_pop),
		.pop_item(back_item)
	);

	csel_back #(
		.NUM_CELLS(NUM_CELLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.item(back_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_shower_id(result_shower_id),
		.is_photon(is_photon)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_pop_needs_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || out_ready))
		else $error("item taken while result register is blocked");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> $past(q_pop, 1) || $past(q_pop, 2))
		else $error("result appeared without a queued item");

endmodule

`default_nettype wire

// ===== hw/rtl/csel_front.sv =====
`default_nettype none

module csel_front
	import csel_pkg::*;
#(
	parameter int unsigned NUM_CELLS = NUM_CELLS_DEF
) (
	input wire cfg_t cfg,
	input wire logic [1:0] req_type,
	input wire logic [3:0] detector_id,
	input wire logic [13:0] cell_id,
	input wire logic [9:0] shower_id,
	input wire logic [13:0] shower_energy,
	input wire logic [11:0] polar_angle,
	input wire logic [10:0] shape_ratio,
	input wire logic [11:0] shower_width,
	input wire logic [7:0] hit_count,
	input wire logic [7:0] quality,
	input wire logic last_of_shower,
	output q_item_t item
);

	localparam logic [CELL_W:0] NUM_CELLS_W = (CELL_W+1)'(NUM_CELLS);

	logic in_range;
	logic low_energy;
	logic base_ok;
	logic low_ok;
	req_e_t req;

	assign req = req_e_t'(req_type);
	assign in_range = ({1'b0, cell_id} < NUM_CELLS_W);
	assign low_energy = (shower_energy < LOW_ENERGY_MEV);
	assign base_ok = (quality == 8'd0) && (polar_angle >= THETA_LOW)
		&& (polar_angle <= THETA_HIGH) && (shower_energy >= cfg.energy_cut);
	assign low_ok = (hit_count > cfg.hit_count_cut)
		&& (shape_ratio >= cfg.shape_ratio_cut) && (shower_width <= cfg.width_cut);

	always_comb begin
		item.req = req;
		item.cell_addr = cell_id;
		item.shower_id = shower_id;
		item.cuts_ok = base_ok && (!low_energy || low_ok);
		item.last = last_of_shower;
		case (req)
			REQ_HIT: item.cell_use = in_range && (cell_id != '0)
				&& (detector_id == cfg.det_id);
			REQ_CELL: item.cell_use = in_range;
			default: item.cell_use = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csel_fifo.sv =====
`default_nettype none

module csel_fifo
	import csel_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire q_item_t push_item,
	output logic full,
	output logic pop_valid,
	input wire logic pop,
	output q_item_t pop_item
);

	q_item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csel_back.sv =====
`default_nettype none

module csel_back
	import csel_pkg::*;
#(
	parameter int unsigned NUM_CELLS = NUM_CELLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire q_item_t item,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [SHOWER_W-1:0] result_shower_id,
	output logic is_photon
);

	localparam int unsigned AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CELLS - 1);

	logic mark_mem [NUM_CELLS];

	back_state_t state_q, state_d;
	logic [AW-1:0] sweep_q;
	logic rd_data_q;
	logic cell_last_q;
	logic cell_use_q;
	logic cuts_q;
	logic matched_q;
	logic [SHOWER_W-1:0] cur_shower_q;

	logic out_free;
	logic wr_en, wr_data, rd_en;
	logic [AW-1:0] wr_addr, rd_addr, item_addr;
	logic emit, emit_flag;
	logic [SHOWER_W-1:0] emit_id;
	logic hit_matched;

	assign out_free = !out_valid || out_ready;
	assign item_addr = item.cell_use ? item.cell_addr[AW-1:0] : '0;
	assign hit_matched = matched_q || (rd_data_q && cell_use_q);

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		wr_en = 1'b0;
		wr_addr = sweep_q;
		wr_data = 1'b0;
		rd_en = 1'b0;
		rd_addr = item_addr;
		emit = 1'b0;
		emit_id = cur_shower_q;
		emit_flag = 1'b0;
		case (state_q)
			BK_SWEEP: begin
				wr_en = 1'b1;
				if (sweep_q == LAST_ADDR) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					case (item.req)
						REQ_CLEAR: state_d = BK_SWEEP;
						REQ_HIT: begin
							wr_en = item.cell_use;
							wr_addr = item_addr;
							wr_data = 1'b1;
						end
						REQ_HEADER: begin
							emit = item.last;
							emit_id = item.shower_id;
							emit_flag = item.cuts_ok;
						end
						REQ_CELL: begin
							rd_en = 1'b1;
							state_d = BK_READ;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_READ: begin
				emit = cell_last_q;
				emit_flag = cuts_q && !hit_matched;
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
			sweep_q <= '0;
			out_valid <= 1'b0;
			cuts_q <= 1'b0;
			matched_q <= 1'b0;
			cur_shower_q <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= (state_q == BK_SWEEP) ? sweep_q + AW'(1) : '0;
			out_valid <= emit || (out_valid && !out_ready);
			if (q_pop && item.req == REQ_HEADER) begin
				cur_shower_q <= item.shower_id;
				cuts_q <= item.cuts_ok;
				matched_q <= 1'b0;
			end else if (state_q == BK_READ) begin
				matched_q <= hit_matched;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cell_last_q <= item.last;
			cell_use_q <= item.cell_use;
		end
		if (emit) begin
			result_shower_id <= emit_id;
			is_photon <= emit_flag;
		end
	end

	// mark memory
	always_ff @(posedge clk) begin
		if (wr_en) mark_mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mark_mem[rd_addr];
	end

endmodule

`default_nettype wire
